>>> hdl/uktm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uktm_pkg
// Shared types, sizes and codes of the card identifier to type map.
// ----------------------------------------------------------------------------
package uktm_pkg;

    localparam int CAPACITY      = 32;
    localparam int MAX_KEY_BYTES = 8;
    localparam int BYTE_W        = 8;
    localparam int KEY_W         = 64;
    localparam int LEN_W         = 4;
    localparam int TYPE_W        = 5;
    localparam int COUNT_W       = 6;
    localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ISSUE_W       = IDX_W + 1;

    localparam int IN_TDATA_W    = 80;
    localparam int IN_TUSER_W    = 2;
    localparam int OUT_TDATA_W   = 16;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_SET    = 2'd1,
        MODE_REMOVE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_BAD_LEN = 2'd2
    } t_status;

    typedef struct packed {
        logic [TYPE_W-1:0] card_type;
        logic [LEN_W-1:0]  key_length;
        logic [KEY_W-1:0]  uid_key;
    } t_entry;

    typedef struct packed {
        logic [1:0]        mode;
        logic [KEY_W-1:0]  uid_key;
        logic [LEN_W-1:0]  key_length;
        logic [TYPE_W-1:0] card_type;
    } t_request;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        t_status            status;
        logic [TYPE_W-1:0]  found_type;
        logic               hit;
    } t_result;

    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            if (b < int'(len)) begin
                m[b*BYTE_W +: BYTE_W] = {BYTE_W{1'b1}};
            end
        end
        return m;
    endfunction

    function automatic logic len_bad(input logic [LEN_W-1:0] len);
        return (len == '0) || (int'(len) > MAX_KEY_BYTES);
    endfunction

endpackage

>>> hdl/uid_keyed_type_map.sv
`timescale 1ns / 1ps
// A good-length request passes the scan, apply and done states, then the
// output register; a bad-length one goes straight from idle to done. A new
// request is taken only in idle, once the last result has left the controller;
// the scan reads the 32 entries one per cycle through the single read port.
// Reset clears the valid bits and the entry count, with no clearing pass; the
// output register lets the next request in while a result waits.
// ----------------------------------------------------------------------------
// uid_keyed_type_map
// Table that maps card identifiers of 1 to 8 bytes to a card type.
// ----------------------------------------------------------------------------
module uid_keyed_type_map
    import uktm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // uid_key[63:0], key_length[67:64], card_type[72:68], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // hit[0], found_type[5:1], status[7:6], entry_count[13:8], zero fill above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_request          req;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;
    logic              res_vld;
    logic              res_rdy;
    t_result           res;
    logic              r_out_vld;
    t_result           r_out;

    assign req.uid_key    = s_axis_tdata[KEY_W-1:0];
    assign req.key_length = s_axis_tdata[KEY_W +: LEN_W];
    assign req.card_type  = s_axis_tdata[KEY_W+LEN_W +: TYPE_W];
    assign req.mode       = s_axis_tuser;

    uktm_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    uktm_scan_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_vld   (s_axis_tvalid),
        .o_req_rdy   (s_axis_tready),
        .i_req       (req),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_res_vld   (res_vld),
        .i_res_rdy   (res_rdy),
        .o_res       (res)
    );

    assign res_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (res_vld && res_rdy) begin
                r_out_vld <= 1'b1;
                r_out     <= res;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(t_result))'(0), r_out};

endmodule

>>> hdl/uktm_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uktm_entry_ram
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module uktm_entry_ram
    import uktm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/uktm_scan_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uktm_scan_ctrl
// Scans the entry memory for a matching key and the lowest free slot, then
// applies the lookup, set or remove and builds the result.
// ----------------------------------------------------------------------------
module uktm_scan_ctrl
    import uktm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_vld,
    output logic             o_req_rdy,
    input  t_request         i_req,
    output logic             o_ram_we,
    output logic [IDX_W-1:0] o_ram_waddr,
    output t_entry           o_ram_wdata,
    output logic [IDX_W-1:0] o_ram_raddr,
    input  t_entry           i_ram_rdata,
    output logic             o_res_vld,
    input  logic             i_res_rdy,
    output t_result          o_res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [1:0]           r_mode;
    logic [KEY_W-1:0]     r_key;
    logic [LEN_W-1:0]     r_len;
    logic [TYPE_W-1:0]    r_ctype;
    logic [ISSUE_W-1:0]   r_issue;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_cmp_valid;
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [TYPE_W-1:0]    r_hit_type;
    logic                 r_free_ok;
    logic [IDX_W-1:0]     r_free_idx;
    logic [CAPACITY-1:0]  r_valid;
    logic [COUNT_W-1:0]   r_count;
    t_result              r_res;

    logic                 cmp_match;
    logic                 last_cmp;
    logic                 issuing;
    logic [COUNT_W-1:0]   n_count;
    logic [CAPACITY-1:0]  n_valid;
    t_result              n_res;

    assign issuing   = (r_state == ST_SCAN) && (r_issue < ISSUE_W'(CAPACITY));
    assign cmp_match = r_cmp_vld && r_cmp_valid
                       && (i_ram_rdata.key_length == r_len)
                       && (i_ram_rdata.uid_key == r_key);
    assign last_cmp  = r_cmp_vld && (r_cmp_idx == IDX_W'(CAPACITY - 1));

    always_comb begin
        n_count          = r_count;
        n_valid          = r_valid;
        n_res.hit        = 1'b0;
        n_res.found_type = '0;
        n_res.status     = STATUS_DONE;
        case (r_mode)
            MODE_SET: begin
                if (r_hit) begin
                    n_res.hit = 1'b1;
                end else if (r_free_ok) begin
                    n_valid[r_free_idx] = 1'b1;
                    n_count             = r_count + 1'b1;
                end else begin
                    n_res.status = STATUS_FULL;
                end
            end
            MODE_REMOVE: begin
                if (r_hit) begin
                    n_res.hit          = 1'b1;
                    n_valid[r_hit_idx] = 1'b0;
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                if (r_hit) begin
                    n_res.hit        = 1'b1;
                    n_res.found_type = r_hit_type;
                end
            end
        endcase
        n_res.entry_count = n_count;
    end

    assign o_ram_raddr = r_issue[IDX_W-1:0];
    assign o_ram_we    = (r_state == ST_APPLY) && (r_mode == MODE_SET)
                         && (r_hit || r_free_ok);
    assign o_ram_waddr = r_hit ? r_hit_idx : r_free_idx;
    assign o_ram_wdata = '{card_type: r_ctype, key_length: r_len, uid_key: r_key};
    assign o_req_rdy   = (r_state == ST_IDLE);
    assign o_res_vld   = (r_state == ST_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_issue   <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else begin
            r_cmp_vld   <= issuing;
            r_cmp_idx   <= r_issue[IDX_W-1:0];
            r_cmp_valid <= r_valid[r_issue[IDX_W-1:0]];
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_vld) begin
                        r_mode    <= i_req.mode;
                        r_key     <= i_req.uid_key & key_mask(i_req.key_length);
                        r_len     <= i_req.key_length;
                        r_ctype   <= i_req.card_type;
                        r_issue   <= '0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        if (len_bad(i_req.key_length)) begin
                            r_res   <= '{entry_count: r_count, status: STATUS_BAD_LEN,
                                         found_type: '0, hit: 1'b0};
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (issuing) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (cmp_match && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_idx  <= r_cmp_idx;
                        r_hit_type <= i_ram_rdata.card_type;
                    end
                    if (r_cmp_vld && !r_cmp_valid && !r_free_ok) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= r_cmp_idx;
                    end
                    if (last_cmp) begin
                        r_state <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    r_valid <= n_valid;
                    r_count <= n_count;
                    r_res   <= n_res;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_res_rdy) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/uktm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uktm_checker
// Port-level checks of the card identifier to type map.
// ----------------------------------------------------------------------------
module uktm_checker
    import uktm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic               hit;
    logic [TYPE_W-1:0]  found_type;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;

    assign hit         = m_axis_tdata[0];
    assign found_type  = m_axis_tdata[TYPE_W:1];
    assign status      = m_axis_tdata[TYPE_W+2:TYPE_W+1];
    assign entry_count = m_axis_tdata[TYPE_W+3 +: COUNT_W];

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> int'(entry_count) <= CAPACITY)
        else $error("entry count above capacity");

    a_bad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == STATUS_BAD_LEN |-> !hit && found_type == '0)
        else $error("bad length request reported a hit");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status == STATUS_FULL
        |-> !hit && int'(entry_count) == CAPACITY)
        else $error("table full reported with free slots");

endmodule

bind uid_keyed_type_map uktm_checker u_uktm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_uid_keyed_type_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uid_keyed_type_map
// Self-checking bench for the card identifier to type map. A short table of
// requests covers bad lengths, the spare mode, set hits, removes and ignored
// key bytes. Random requests drawn mostly from a fixed key pool then fill,
// update and drain the table, so full-table sets occur. Every result is
// compared field by field with its typed row's result, else with a model of
// the table kept in the bench, under changing source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_uid_keyed_type_map;
    import uktm_pkg::*;

    localparam logic [1:0]       MODE_SPARE  = 2'd3;
    localparam logic [KEY_W-1:0] KEY_ALL     = '1;
    localparam int               POOL_SIZE   = 40;
    localparam int               PHASES      = 8;
    localparam int               PHASE_ITEMS = 180;
    localparam int               MAX_SHOWN   = 10;

    typedef struct {
        t_request req;
        bit       typed;
        t_result  want;
    } t_dir_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // uid_key[63:0], key_length[67:64], card_type[72:68], zero fill above
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // mode[1:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // hit[0], found_type[5:1], status[7:6], entry_count[13:8], zero fill above
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [KEY_W-1:0]  tbl_key   [CAPACITY];
    logic [LEN_W-1:0]  tbl_len   [CAPACITY];
    logic [TYPE_W-1:0] tbl_type  [CAPACITY];
    bit                tbl_valid [CAPACITY];
    int                tbl_count;

    logic [KEY_W-1:0]  pool_key [POOL_SIZE];
    logic [LEN_W-1:0]  pool_len [POOL_SIZE];

    int phase_set_pct    [PHASES] = '{70, 40, 20, 75, 20, 70, 40, 20};
    int phase_remove_pct [PHASES] = '{10, 25, 50, 10, 50, 10, 25, 50};

    t_result  pending_results[$];
    t_dir_row dir_rows[$];
    int       send_idle_pct;
    int       sink_stall_pct;
    int       sink_stall_left;
    int       mismatch_count;

    uid_keyed_type_map dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        if (len >= MAX_KEY_BYTES) begin
            return '1;
        end
        return (64'd1 << (BYTE_W * len)) - 64'd1;
    endfunction

    function automatic void add_row(input t_dir_row d);
        dir_rows = {dir_rows, d};
    endfunction

    function automatic t_result apply_to_table(input t_request r);
        t_result          res;
        logic [KEY_W-1:0] k;
        int               slot;
        int               free_slot;
        res = '0;
        if (r.key_length == '0 || r.key_length > MAX_KEY_BYTES) begin
            res.status = STATUS_BAD_LEN;
        end else begin
            k         = r.uid_key & byte_mask(r.key_length);
            slot      = -1;
            free_slot = -1;
            for (int i = CAPACITY - 1; i >= 0; i--) begin
                if (tbl_valid[i] && tbl_len[i] == r.key_length && tbl_key[i] == k) begin
                    slot = i;
                end
                if (!tbl_valid[i]) begin
                    free_slot = i;
                end
            end
            case (r.mode)
                MODE_SET: begin
                    if (slot >= 0) begin
                        tbl_type[slot] = r.card_type;
                        res.hit        = 1'b1;
                    end else if (free_slot >= 0) begin
                        tbl_key[free_slot]   = k;
                        tbl_len[free_slot]   = r.key_length;
                        tbl_type[free_slot]  = r.card_type;
                        tbl_valid[free_slot] = 1'b1;
                        tbl_count++;
                    end else begin
                        res.status = STATUS_FULL;
                    end
                end
                MODE_REMOVE: begin
                    if (slot >= 0) begin
                        tbl_valid[slot] = 1'b0;
                        if (tbl_count > 0) begin
                            tbl_count--;
                        end
                        res.hit = 1'b1;
                    end
                end
                default: begin
                    if (slot >= 0) begin
                        res.hit        = 1'b1;
                        res.found_type = tbl_type[slot];
                    end
                end
            endcase
        end
        res.entry_count = COUNT_W'(tbl_count);
        return res;
    endfunction

    function automatic t_dir_row dir_row(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                                         input int len, input int ctype, input bit typed,
                                         input bit hit, input int ftype, input t_status st,
                                         input int cnt);
        t_dir_row d;
        d.req.mode             = mode;
        d.req.uid_key          = key;
        d.req.key_length       = LEN_W'(len);
        d.req.card_type        = TYPE_W'(ctype);
        d.typed                = typed;
        d.want.hit             = hit;
        d.want.found_type      = TYPE_W'(ftype);
        d.want.status          = st;
        d.want.entry_count     = COUNT_W'(cnt);
        return d;
    endfunction

    function automatic t_request random_request(input int set_pct, input int remove_pct);
        t_request r;
        int       pick;
        int       p;
        pick = $urandom_range(99);
        if (pick < set_pct) begin
            r.mode = MODE_SET;
        end else if (pick < set_pct + remove_pct) begin
            r.mode = MODE_REMOVE;
        end else if ($urandom_range(29) == 0) begin
            r.mode = MODE_SPARE;
        end else begin
            r.mode = MODE_LOOKUP;
        end
        r.card_type = TYPE_W'($urandom);
        pick        = $urandom_range(99);
        if (pick < 5) begin
            p            = $urandom_range(7);
            r.key_length = (p == 0) ? LEN_W'(0) : LEN_W'(p + 8);
            r.uid_key    = {$urandom, $urandom};
        end else if (pick < 15) begin
            r.key_length = LEN_W'($urandom_range(8, 1));
            r.uid_key    = {$urandom, $urandom};
        end else begin
            p            = $urandom_range(POOL_SIZE - 1);
            r.key_length = pool_len[p];
            r.uid_key    = pool_key[p] | ({$urandom, $urandom} & ~byte_mask(pool_len[p]));
        end
        return r;
    endfunction

    task automatic send_request(input t_request r, input bit typed, input t_result want);
        t_result predicted;
        int      gap;
        predicted = apply_to_table(r);
        pending_results = {pending_results, (typed ? want : predicted)};
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({r.card_type, r.key_length, r.uid_key});
        s_axis_tuser  <= r.mode;
        do @(posedge i_clk); while (!s_axis_tready);
        if ($urandom_range(99) < send_idle_pct) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(45, 4) : $urandom_range(3, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (sink_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            sink_stall_left--;
        end else if ($urandom_range(99) < sink_stall_pct) begin
            m_axis_tready <= 1'b0;
            if ($urandom_range(15) == 0) begin
                sink_stall_left = $urandom_range(80, 20);
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_results.size() == 0) begin
                if (mismatch_count < MAX_SHOWN) begin
                    $display("unexpected result %h with no request pending", m_axis_tdata);
                end
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.hit != want.hit || got.found_type != want.found_type ||
                    got.status != want.status || got.entry_count != want.entry_count) begin
                    if (mismatch_count < MAX_SHOWN) begin
                        $display("mismatch (expected/actual): hit %0d/%0d type %0d/%0d %s",
                                 want.hit, got.hit, want.found_type, got.found_type,
                                 $sformatf("status %0d/%0d count %0d/%0d",
                                           want.status, got.status,
                                           want.entry_count, got.entry_count));
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] raw;
        for (int i = 0; i < POOL_SIZE; i++) begin
            // Odd entries share the bytes of their neighbor with another length.
            if (i % 2 == 0) begin
                raw         = {$urandom, $urandom};
                pool_len[i] = LEN_W'($urandom_range(8, 1));
            end else begin
                pool_len[i] = LEN_W'(pool_len[i-1] % 8 + 1);
            end
            pool_key[i] = raw & byte_mask(pool_len[i]);
        end

        add_row(dir_row(MODE_LOOKUP, 64'h0, 1, 0, 1, 0, 0, STATUS_DONE, 0));
        add_row(dir_row(MODE_LOOKUP, KEY_ALL, 0, 0, 1, 0, 0, STATUS_BAD_LEN, 0));
        add_row(dir_row(MODE_SET, KEY_ALL, 15, 31, 1, 0, 0, STATUS_BAD_LEN, 0));
        add_row(dir_row(MODE_SET, KEY_ALL, 9, 1, 1, 0, 0, STATUS_BAD_LEN, 0));
        add_row(dir_row(MODE_SET, KEY_ALL, 8, 20, 1, 0, 0, STATUS_DONE, 1));
        add_row(dir_row(MODE_LOOKUP, KEY_ALL, 8, 0, 1, 1, 20, STATUS_DONE, 1));
        add_row(dir_row(MODE_LOOKUP, KEY_ALL, 7, 0, 1, 0, 0, STATUS_DONE, 1));
        add_row(dir_row(MODE_SET, 64'hAB, 1, 0, 1, 0, 0, STATUS_DONE, 2));
        add_row(dir_row(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFAB, 1, 0, 1, 1, 0,
                        STATUS_DONE, 2));
        add_row(dir_row(MODE_SET, KEY_ALL, 8, 31, 1, 1, 0, STATUS_DONE, 2));
        add_row(dir_row(MODE_SPARE, KEY_ALL, 8, 3, 1, 1, 31, STATUS_DONE, 2));
        add_row(dir_row(MODE_REMOVE, KEY_ALL, 8, 5, 1, 1, 0, STATUS_DONE, 1));
        add_row(dir_row(MODE_REMOVE, KEY_ALL, 8, 0, 1, 0, 0, STATUS_DONE, 1));
        add_row(dir_row(MODE_REMOVE, 64'hAB, 0, 0, 1, 0, 0, STATUS_BAD_LEN, 1));
        add_row(dir_row(MODE_SPARE, 64'h0, 12, 0, 1, 0, 0, STATUS_BAD_LEN, 1));
        add_row(dir_row(MODE_SET, 64'h0123_4567_89AB_CDEF, 4, 7, 0, 0, 0,
                        STATUS_DONE, 0));
        add_row(dir_row(MODE_LOOKUP, 64'hFFFF_FFFF_89AB_CDEF, 4, 0, 0, 0, 0,
                        STATUS_DONE, 0));
        add_row(dir_row(MODE_LOOKUP, 64'h0123_4567_89AB_CDEF, 5, 0, 0, 0, 0,
                        STATUS_DONE, 0));
        add_row(dir_row(MODE_SET, 64'h0, 8, 21, 0, 0, 0, STATUS_DONE, 0));
        add_row(dir_row(MODE_LOOKUP, 64'h5A00_0000_0000_0000, 7, 0, 0, 0, 0,
                        STATUS_DONE, 0));
        add_row(dir_row(MODE_LOOKUP, 64'h0, 8, 0, 0, 0, 0, STATUS_DONE, 0));
        add_row(dir_row(MODE_REMOVE, 64'h0123_4567_89AB_CDEF, 4, 0, 0, 0, 0,
                        STATUS_DONE, 0));
        add_row(dir_row(MODE_SPARE, 64'hAB, 1, 0, 0, 0, 0, STATUS_DONE, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 50;
                    sink_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 50;
                end
                default: begin
                    send_idle_pct  = 26;
                    sink_stall_pct = 26;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                send_request(random_request(phase_set_pct[p], phase_remove_pct[p]), 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/uktm_pkg.sv
hdl/uktm_entry_ram.sv
hdl/uktm_scan_ctrl.sv
hdl/uid_keyed_type_map.sv
hdl/uktm_checker.sv
tb/tb_uid_keyed_type_map.sv
